@@ sv/pob_pkg.sv @@
// ----------------------------------------------------------------------------
// pob_pkg: shared types and constants for the polyline offset boundaries unit
// Holds the fixed field widths, the lane width reset value and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pob_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int LANE_W          = 22;
	localparam int HALF_W          = LANE_W - 1;
	localparam int UNIT_W          = 18;
	localparam int UNIT_FRAC       = 16;
	localparam logic [LANE_W-1:0] LANE_RESET = 22'd229376;

	// Which point and which unit vector feed the boundary computation.
	typedef enum logic [1:0] {
		EM_LONE,
		EM_HELD,
		EM_CUR
	} emit_sel_t;

	typedef struct packed {
		logic      cap_in;
		logic      hold_in;
		logic      norm_start;
		logic      norm_sum;
		logic      cap_d;
		logic      commit;
		logic      emit_load;
		emit_sel_t emit_sel;
		logic      out_load;
	} pob_cmd_t;

	typedef struct packed {
		logic norm_done;
		logic out_free;
	} pob_stat_t;

endpackage

`default_nettype wire

@@ sv/pob_norm.sv @@
// ----------------------------------------------------------------------------
// pob_norm: iterative vector normalizer
// Scales the magnitudes into [2^29, 2^30), forms the squared length with one
// shared multiplier, takes an integer square root one bit pair per cycle and
// divides both components by it one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pob_norm #(
	parameter int NW = 33
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	input  wire  signed [NW-1:0]                vx,
	input  wire  signed [NW-1:0]                vy,
	output logic                                done,
	output logic signed [pob_pkg::UNIT_W-1:0]   ux,
	output logic signed [pob_pkg::UNIT_W-1:0]   uy
);

	localparam int AW = ((NW > 30) ? NW : 30) + 1;
	localparam int QW = pob_pkg::UNIT_FRAC + 1;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SHIFT,
		N_SQ1,
		N_SQ2,
		N_ROOT,
		N_DIV
	} nstate_t;

	nstate_t     st_q;
	logic        done_q;
	logic [AW-1:0] ax_q, ay_q;
	logic        sx_q, sy_q;
	logic [61:0] n_q, res_q, bit_q;
	logic [30:0] remx_q, remy_q;
	logic [QW-1:0] numx_q, numy_q, qx_q, qy_q;
	logic [4:0]  cnt_q;
	logic signed [pob_pkg::UNIT_W-1:0] ux_q, uy_q;

	logic [NW-1:0] mvx, mvy;
	logic [AW-1:0] m;
	logic [29:0]   sq_op;
	logic [59:0]   prod;
	logic [61:0]   trial;
	logic [30:0]   root;
	logic [46:0]   numx, numy;
	logic [31:0]   tx, ty;
	logic          gex, gey;

	always_comb begin
		mvx   = vx[NW-1] ? NW'(-vx) : NW'(vx);
		mvy   = vy[NW-1] ? NW'(-vy) : NW'(vy);
		m     = (ax_q > ay_q) ? ax_q : ay_q;
		sq_op = (st_q == N_SQ1) ? ax_q[29:0] : ay_q[29:0];
		prod  = sq_op * sq_op;
		trial = res_q + bit_q;
		root  = res_q[30:0];
		numx  = 47'({ax_q[29:0], 16'b0}) + 47'(root[30:1]);
		numy  = 47'({ay_q[29:0], 16'b0}) + 47'(root[30:1]);
		tx    = {remx_q, numx_q[QW-1]};
		ty    = {remy_q, numy_q[QW-1]};
		gex   = tx >= {1'b0, root};
		gey   = ty >= {1'b0, root};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= N_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				N_IDLE: begin
					if (start) begin
						if (mvx == '0 && mvy == '0) begin
							done_q <= 1'b1;
						end else begin
							st_q <= N_SHIFT;
						end
					end
				end
				N_SHIFT: begin
					if (m[AW-1:30] == '0 && m[29]) begin
						st_q <= N_SQ1;
					end
				end
				N_SQ1: st_q <= N_SQ2;
				N_SQ2: st_q <= N_ROOT;
				N_ROOT: begin
					if (bit_q == '0) begin
						st_q <= N_DIV;
					end
				end
				N_DIV: begin
					if (cnt_q == '0) begin
						st_q   <= N_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			N_IDLE: begin
				if (start) begin
					ax_q <= AW'(mvx);
					ay_q <= AW'(mvy);
					sx_q <= vx[NW-1];
					sy_q <= vy[NW-1];
					ux_q <= '0;
					uy_q <= '0;
				end
			end
			N_SHIFT: begin
				if (m[AW-1:30] != '0) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
				end else if (m[29:25] == '0) begin
					ax_q <= ax_q << 4;
					ay_q <= ay_q << 4;
				end else if (!m[29]) begin
					ax_q <= ax_q << 1;
					ay_q <= ay_q << 1;
				end
			end
			N_SQ1: n_q <= 62'(prod);
			N_SQ2: begin
				n_q   <= n_q + 62'(prod);
				res_q <= '0;
				bit_q <= 62'(1) << 60;
			end
			N_ROOT: begin
				if (bit_q != '0) begin
					if (n_q >= trial) begin
						n_q   <= n_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					// The quotient stays below 2^17, so the top of the
					// numerator is already smaller than the root.
					remx_q <= 31'(numx[46:QW]);
					remy_q <= 31'(numy[46:QW]);
					numx_q <= numx[QW-1:0];
					numy_q <= numy[QW-1:0];
					cnt_q  <= 5'(QW);
				end
			end
			N_DIV: begin
				if (cnt_q != '0) begin
					remx_q <= gex ? 31'(tx - {1'b0, root}) : tx[30:0];
					remy_q <= gey ? 31'(ty - {1'b0, root}) : ty[30:0];
					qx_q   <= {qx_q[QW-2:0], gex};
					qy_q   <= {qy_q[QW-2:0], gey};
					numx_q <= numx_q << 1;
					numy_q <= numy_q << 1;
					cnt_q  <= cnt_q - 5'd1;
				end else begin
					ux_q <= sx_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
					uy_q <= sy_q ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign ux   = ux_q;
	assign uy   = uy_q;

endmodule

`default_nettype wire

@@ sv/pob_datapath.sv @@
// ----------------------------------------------------------------------------
// pob_datapath: point registers, normalizer, offset scaling and output word
// Follows the controller's commands; reports normalizer completion and
// whether the output register can take a new word.
// ----------------------------------------------------------------------------
`default_nettype none

module pob_datapath #(
	parameter int COORD_WIDTH = pob_pkg::COORD_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_wr_en,
	input  wire  [pob_pkg::LANE_W-1:0]       cfg_wr_data,
	input  wire  signed [COORD_WIDTH-1:0]    point_x,
	input  wire  signed [COORD_WIDTH-1:0]    point_y,
	input  pob_pkg::pob_cmd_t                cmd,
	output pob_pkg::pob_stat_t               stat,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic signed [COORD_WIDTH-1:0]    left_x,
	output logic signed [COORD_WIDTH-1:0]    left_y,
	output logic signed [COORD_WIDTH-1:0]    right_x,
	output logic signed [COORD_WIDTH-1:0]    right_y,
	output logic                             last_out
);

	localparam int UW   = pob_pkg::UNIT_W;
	localparam int NW   = (COORD_WIDTH + 1 > UW + 1) ? COORD_WIDTH + 1 : UW + 1;
	localparam int MW   = UW - 1;
	localparam int PW   = MW + pob_pkg::HALF_W;
	localparam int OW   = PW - pob_pkg::UNIT_FRAC + 1;
	localparam int SUMW = ((COORD_WIDTH > OW) ? COORD_WIDTH : OW) + 1;
	localparam logic signed [SUMW-1:0] SAT_HI =
		{{(SUMW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

	logic [pob_pkg::LANE_W-1:0] lane_q;
	logic signed [COORD_WIDTH-1:0] cur_x_q, cur_y_q, held_x_q, held_y_q;
	logic signed [UW-1:0] hdir_x_q, hdir_y_q, d_x_q, d_y_q;
	logic signed [COORD_WIDTH-1:0] e_px_q, e_py_q;
	logic signed [UW-1:0] e_ux_q, e_uy_q;
	logic e_last_q;
	logic [PW-1:0] pm_x_s1, pm_y_s1;
	logic negx_s1, negy_s1;
	logic signed [OW-1:0] ox_s2, oy_s2;
	logic out_valid_q;
	logic signed [COORD_WIDTH-1:0] lx_q, ly_q, rx_q, ry_q;
	logic lo_q;

	logic signed [NW-1:0] nvx, nvy;
	logic norm_done;
	logic signed [UW-1:0] norm_ux, norm_uy;
	logic [MW-1:0] mag_ux, mag_uy;
	logic [pob_pkg::HALF_W-1:0] half;
	logic [PW:0] rnd_x, rnd_y;
	logic signed [SUMW-1:0] s_lx, s_ly, s_rx, s_ry;

	function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SUMW-1:0] v);
		logic signed [COORD_WIDTH-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[COORD_WIDTH-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[COORD_WIDTH-1:0];
		end else begin
			r = v[COORD_WIDTH-1:0];
		end
		return r;
	endfunction

	always_comb begin
		if (cmd.norm_sum) begin
			nvx = NW'(hdir_x_q) + NW'(d_x_q);
			nvy = NW'(hdir_y_q) + NW'(d_y_q);
		end else begin
			nvx = NW'(cur_x_q) - NW'(held_x_q);
			nvy = NW'(cur_y_q) - NW'(held_y_q);
		end
	end

	pob_norm #(.NW(NW)) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.norm_start),
		.vx     (nvx),
		.vy     (nvy),
		.done   (norm_done),
		.ux     (norm_ux),
		.uy     (norm_uy)
	);

	always_comb begin
		half   = lane_q[pob_pkg::LANE_W-1:1];
		mag_ux = e_ux_q[UW-1] ? MW'(-e_ux_q) : e_ux_q[MW-1:0];
		mag_uy = e_uy_q[UW-1] ? MW'(-e_uy_q) : e_uy_q[MW-1:0];
		rnd_x  = {1'b0, pm_x_s1} + (PW+1)'(1 << (pob_pkg::UNIT_FRAC - 1));
		rnd_y  = {1'b0, pm_y_s1} + (PW+1)'(1 << (pob_pkg::UNIT_FRAC - 1));
		s_lx   = SUMW'(e_px_q) + SUMW'(ox_s2);
		s_ly   = SUMW'(e_py_q) + SUMW'(oy_s2);
		s_rx   = SUMW'(e_px_q) - SUMW'(ox_s2);
		s_ry   = SUMW'(e_py_q) - SUMW'(oy_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q      <= pob_pkg::LANE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				lane_q <= cfg_wr_data;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			cur_x_q <= point_x;
			cur_y_q <= point_y;
		end
		if (cmd.hold_in) begin
			held_x_q <= point_x;
			held_y_q <= point_y;
		end else if (cmd.commit) begin
			held_x_q <= cur_x_q;
			held_y_q <= cur_y_q;
		end
		if (cmd.commit) begin
			hdir_x_q <= d_x_q;
			hdir_y_q <= d_y_q;
		end
		if (cmd.cap_d) begin
			d_x_q <= norm_ux;
			d_y_q <= norm_uy;
		end
		if (cmd.emit_load) begin
			unique case (cmd.emit_sel)
				pob_pkg::EM_LONE: begin
					// A lone point is loaded straight from the input word.
					e_px_q   <= point_x;
					e_py_q   <= point_y;
					e_ux_q   <= '0;
					e_uy_q   <= '0;
					e_last_q <= 1'b1;
				end
				pob_pkg::EM_HELD: begin
					e_px_q   <= held_x_q;
					e_py_q   <= held_y_q;
					e_ux_q   <= norm_ux;
					e_uy_q   <= norm_uy;
					e_last_q <= 1'b0;
				end
				pob_pkg::EM_CUR: begin
					e_px_q   <= cur_x_q;
					e_py_q   <= cur_y_q;
					e_ux_q   <= d_x_q;
					e_uy_q   <= d_y_q;
					e_last_q <= 1'b1;
				end
				default: begin
					e_px_q   <= cur_x_q;
					e_py_q   <= cur_y_q;
					e_ux_q   <= '0;
					e_uy_q   <= '0;
					e_last_q <= 1'b1;
				end
			endcase
		end
		// The normal is (-uy, ux): the x offset is negative when uy is positive.
		pm_x_s1 <= mag_uy * half;
		pm_y_s1 <= mag_ux * half;
		negx_s1 <= !e_uy_q[UW-1] && (e_uy_q != '0);
		negy_s1 <= e_ux_q[UW-1];
		ox_s2   <= negx_s1 ? -$signed({1'b0, rnd_x[PW-1:pob_pkg::UNIT_FRAC]})
		                   : $signed({1'b0, rnd_x[PW-1:pob_pkg::UNIT_FRAC]});
		oy_s2   <= negy_s1 ? -$signed({1'b0, rnd_y[PW-1:pob_pkg::UNIT_FRAC]})
		                   : $signed({1'b0, rnd_y[PW-1:pob_pkg::UNIT_FRAC]});
		if (cmd.out_load) begin
			lx_q <= sat(s_lx);
			ly_q <= sat(s_ly);
			rx_q <= sat(s_rx);
			ry_q <= sat(s_ry);
			lo_q <= e_last_q;
		end
	end

	assign stat.norm_done = norm_done;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign left_x         = lx_q;
	assign left_y         = ly_q;
	assign right_x        = rx_q;
	assign right_y        = ry_q;
	assign last_out       = lo_q;

endmodule

`default_nettype wire

@@ sv/pob_ctrl.sv @@
// ----------------------------------------------------------------------------
// pob_ctrl: sequencing controller
// Tracks how many points of the current polyline are held, runs up to two
// normalizations per point and steps each boundary word through the offset
// stages into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pob_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire                 last_point,
	input  pob_pkg::pob_stat_t  stat,
	output pob_pkg::pob_cmd_t   cmd
);

	localparam logic [1:0] SEEN_NONE  = 2'd0;
	localparam logic [1:0] SEEN_FIRST = 2'd1;
	localparam logic [1:0] SEEN_MORE  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_N1_GO,
		S_N1_WAIT,
		S_N2_GO,
		S_N2_WAIT,
		S_E_MUL,
		S_E_RND,
		S_E_WR
	} state_t;

	typedef enum logic [1:0] {
		PH_LONE,
		PH_FIRST,
		PH_SECOND
	} phase_t;

	state_t     st_q;
	phase_t     ph_q;
	logic [1:0] seen_q;
	logic       last_q;

	always_comb begin
		cmd = '0;
		cmd.emit_sel = pob_pkg::EM_HELD;
		in_ready = (st_q == S_IDLE);
		unique case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					if (seen_q == SEEN_NONE) begin
						if (last_point) begin
							cmd.emit_load = 1'b1;
							cmd.emit_sel  = pob_pkg::EM_LONE;
						end else begin
							cmd.hold_in = 1'b1;
						end
					end
				end
			end
			S_N1_GO: cmd.norm_start = 1'b1;
			S_N1_WAIT: begin
				if (stat.norm_done) begin
					cmd.cap_d     = 1'b1;
					cmd.emit_load = (seen_q == SEEN_FIRST);
				end
			end
			S_N2_GO: begin
				cmd.norm_start = 1'b1;
				cmd.norm_sum   = 1'b1;
			end
			S_N2_WAIT: begin
				cmd.norm_sum  = 1'b1;
				cmd.emit_load = stat.norm_done;
			end
			S_E_WR: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (ph_q == PH_FIRST) begin
						cmd.commit    = 1'b1;
						cmd.emit_load = last_q;
						cmd.emit_sel  = pob_pkg::EM_CUR;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			ph_q   <= PH_LONE;
			seen_q <= SEEN_NONE;
			last_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= last_point;
						if (seen_q == SEEN_NONE) begin
							if (last_point) begin
								ph_q <= PH_LONE;
								st_q <= S_E_MUL;
							end else begin
								seen_q <= SEEN_FIRST;
							end
						end else begin
							st_q <= S_N1_GO;
						end
					end
				end
				S_N1_GO: st_q <= S_N1_WAIT;
				S_N1_WAIT: begin
					if (stat.norm_done) begin
						if (seen_q == SEEN_FIRST) begin
							ph_q <= PH_FIRST;
							st_q <= S_E_MUL;
						end else begin
							st_q <= S_N2_GO;
						end
					end
				end
				S_N2_GO: st_q <= S_N2_WAIT;
				S_N2_WAIT: begin
					if (stat.norm_done) begin
						ph_q <= PH_FIRST;
						st_q <= S_E_MUL;
					end
				end
				S_E_MUL: st_q <= S_E_RND;
				S_E_RND: st_q <= S_E_WR;
				S_E_WR: begin
					if (stat.out_free) begin
						if (ph_q == PH_FIRST && last_q) begin
							// The final point flushes its own word right behind.
							seen_q <= SEEN_NONE;
							ph_q   <= PH_SECOND;
							st_q   <= S_E_MUL;
						end else begin
							if (ph_q == PH_FIRST) begin
								seen_q <= SEEN_MORE;
							end
							st_q <= S_IDLE;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/polyline_offset_boundaries_unit.sv @@
// ----------------------------------------------------------------------------
// polyline_offset_boundaries_unit: left and right lane boundaries of a polyline
// Offsets each centre-line point by half the lane width along its miter
// normal, one point behind the input; the final point flushes two words, a lone point one.
// ----------------------------------------------------------------------------
//  channel  | signals                                       | handshake
//  ---------+-----------------------------------------------+-----------
//  input    | point_x, point_y, last_point                  | in_valid/in_ready
//  output   | left_x, left_y, right_x, right_y, last_out    | out_valid/out_ready
//  config   | cfg_wr_data (lane_width)                      | cfg_wr_en
//
// One point is worked at a time. A normalization through the shared iterative
// unit runs magnitude scaling (one bit right, or four or one bits left, per
// cycle), the squared length, the square root and the divide; a zero vector
// skips these steps and yields a zero unit vector. The second point of a
// polyline needs one normalization, each later point two. Each word then
// steps through the multiply, rounding and write states, saturated at the write.
// A first point that is not also the last is only held. A stalled output holds
// the controller in its write state until the last result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_offset_boundaries_unit #(
	parameter int COORD_WIDTH = pob_pkg::COORD_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_wr_en,
	input  wire  [pob_pkg::LANE_W-1:0]       cfg_wr_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  signed [COORD_WIDTH-1:0]    point_x,
	input  wire  signed [COORD_WIDTH-1:0]    point_y,
	input  wire                              last_point,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic signed [COORD_WIDTH-1:0]    left_x,
	output logic signed [COORD_WIDTH-1:0]    left_y,
	output logic signed [COORD_WIDTH-1:0]    right_x,
	output logic signed [COORD_WIDTH-1:0]    right_y,
	output logic                             last_out
);

	pob_pkg::pob_cmd_t  cmd;
	pob_pkg::pob_stat_t stat;

	pob_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.last_point (last_point),
		.stat       (stat),
		.cmd        (cmd)
	);

	pob_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.point_x     (point_x),
		.point_y     (point_y),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.left_x      (left_x),
		.left_y      (left_y),
		.right_x     (right_x),
		.right_y     (right_y),
		.last_out    (last_out)
	);

endmodule

`default_nettype wire

@@ test/pob_checker.sv @@
// ----------------------------------------------------------------------------
// pob_checker: boundary predictor and scoreboard for the offset unit
// Watches the input and output channels, predicts each boundary word from
// the accepted points and the lane width, and counts every mismatch.
// ----------------------------------------------------------------------------
`default_nettype none

module pob_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_wr_en,
	input  wire  [21:0]       cfg_wr_data,
	input  wire               in_valid,
	input  wire               in_ready,
	input  wire  signed [31:0] point_x,
	input  wire  signed [31:0] point_y,
	input  wire               last_point,
	input  wire               out_valid,
	input  wire               out_ready,
	input  wire  signed [31:0] left_x,
	input  wire  signed [31:0] left_y,
	input  wire  signed [31:0] right_x,
	input  wire  signed [31:0] right_y,
	input  wire               last_out,
	output int                fail_count,
	output int                pending
);

	typedef struct {
		logic signed [31:0] lx, ly, rx, ry;
		logic               lst;
	} bound_t;

	bound_t              bound_q[$];
	logic [21:0]         lane;
	longint              prev_x, prev_y;
	longint              prev_dx, prev_dy;
	int                  seen;

	assign pending = bound_q.size();

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n) bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	task automatic unit_vec(input longint vx, input longint vy,
			output longint ux, output longint uy);
		longint unsigned ax, ay, m, r, qx, qy;
		ax = vx < 0 ? -vx : vx;
		ay = vy < 0 ? -vy : vy;
		m = ax > ay ? ax : ay;
		if (m == 0) begin
			ux = 0;
			uy = 0;
			return;
		end
		while (m >= (64'd1 << 30)) begin ax >>= 1; ay >>= 1; m >>= 1; end
		while (m < (64'd1 << 29)) begin ax <<= 1; ay <<= 1; m <<= 1; end
		r = root64(ax * ax + ay * ay);
		qx = (ax * 65536 + (r >> 1)) / r;
		qy = (ay * 65536 + (r >> 1)) / r;
		ux = vx < 0 ? -longint'(qx) : longint'(qx);
		uy = vy < 0 ? -longint'(qy) : longint'(qy);
	endtask

	function automatic longint offset_of(longint u, longint half);
		longint q;
		q = ((u < 0 ? -u : u) * half + 32768) >>> 16;
		return u < 0 ? -q : q;
	endfunction

	function automatic logic signed [31:0] clamp(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	task automatic push_bound(longint px, longint py, longint ux, longint uy, logic lst);
		bound_t b;
		longint half, ox, oy;
		half = lane >> 1;
		ox = offset_of(-uy, half);
		oy = offset_of(ux, half);
		b.lx = clamp(px + ox);
		b.ly = clamp(py + oy);
		b.rx = clamp(px - ox);
		b.ry = clamp(py - oy);
		b.lst = lst;
		bound_q.insert(bound_q.size(), b);
	endtask

	task automatic take_point(longint px, longint py, logic lst);
		longint dx, dy, nx, ny;
		if (seen == 0) begin
			if (lst) begin
				push_bound(px, py, 0, 0, 1'b1);
			end else begin
				prev_x = px;
				prev_y = py;
				seen = 1;
			end
			return;
		end
		unit_vec(px - prev_x, py - prev_y, dx, dy);
		if (seen == 1) begin
			nx = dx;
			ny = dy;
		end else begin
			unit_vec(prev_dx + dx, prev_dy + dy, nx, ny);
		end
		push_bound(prev_x, prev_y, nx, ny, 1'b0);
		if (lst) begin
			push_bound(px, py, dx, dy, 1'b1);
			seen = 0;
		end else begin
			seen = 2;
		end
		prev_x = px;
		prev_y = py;
		prev_dx = dx;
		prev_dy = dy;
	endtask

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bound_t b;
		if (!arst_n) begin
			lane <= 22'd229376;
			seen = 0;
			fail_count = 0;
			bound_q.delete();
		end else begin
			if (in_valid && in_ready)
				take_point(point_x, point_y, last_point);
			if (out_valid && out_ready) begin
				if (bound_q.size() == 0) begin
					$error("Unexpected boundary word");
					fail_count++;
				end else begin
					b = bound_q.pop_front();
					check_field("left_x", b.lx, left_x);
					check_field("left_y", b.ly, left_y);
					check_field("right_x", b.rx, right_x);
					check_field("right_y", b.ry, right_y);
					check_field("last_out", b.lst, last_out);
				end
			end
			if (cfg_wr_en)
				lane <= cfg_wr_data;
		end
	end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: stimulus for the polyline offset boundaries unit
// Feeds directed and random polylines in bursts under several lane widths,
// with a stalling receiver, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_wr_en = 0;
	logic [21:0]        cfg_wr_data = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic signed [31:0] point_x = 0, point_y = 0;
	logic               last_point = 0;
	logic               out_valid, out_ready = 0;
	logic signed [31:0] left_x, left_y, right_x, right_y;
	logic               last_out;
	int                 fail_count, pending;
	int                 gap_left = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	polyline_offset_boundaries_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .point_x(point_x), .point_y(point_y),
		.last_point(last_point), .out_valid(out_valid), .out_ready(out_ready),
		.left_x(left_x), .left_y(left_y), .right_x(right_x), .right_y(right_y),
		.last_out(last_out)
	);

	pob_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .point_x(point_x), .point_y(point_y),
		.last_point(last_point), .out_valid(out_valid), .out_ready(out_ready),
		.left_x(left_x), .left_y(left_y), .right_x(right_x), .right_y(right_y),
		.last_out(last_out), .fail_count(fail_count), .pending(pending)
	);

	// The receiver stalls at random under a randomly drawn mode; mode 0 never stalls.
	always @(posedge clk) begin
		int mode;
		mode = $urandom_range(0, 3);
		if (mode == 0) out_ready <= 1'b1;
		else if (mode == 1) out_ready <= ($urandom_range(0, 7) == 0);
		else out_ready <= ($urandom_range(0, 3) != 0);
	end

	// Sends one word; gaps fall between bursts. Valid stays high inside a burst.
	task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic lst);
		if (gap_left == 0) begin
			gap_left = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		gap_left--;
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		last_point <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain_and_set(logic [21:0] w);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_coord(int kind);
		case (kind)
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 65536)
			                            : 32'sh80000000 + $urandom_range(0, 65536);
			default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
		endcase
	endfunction

	initial begin
		logic [21:0]        widths[5];
		logic signed [31:0] x, y;
		int                 n, kind;
		widths = '{22'd0, 22'd2097152, 22'd1, 22'd3, 22'd229376};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Lone point, zero-length segment, reversal, extremes.
		send_point(32'sd100, -32'sd100, 1'b1);
		send_point(32'sd5, 32'sd5, 1'b0);
		send_point(32'sd5, 32'sd5, 1'b1);
		send_point(0, 0, 1'b0);
		send_point(32'sd65536, 0, 1'b0);
		send_point(0, 0, 1'b0);
		send_point(0, 32'sd65536, 1'b1);
		send_point(32'sh7fffffff, 32'sh7fffffff, 1'b0);
		send_point(32'sh80000000, 32'sh80000000, 1'b0);
		send_point(32'sh7fffffff, 32'sh80000000, 1'b1);
		drain_and_set(22'h3fffff);
		send_point(32'sh7fffff00, 0, 1'b0);
		send_point(32'sh7fffffff, 32'sh7fffffff, 1'b0);
		send_point(32'sh80000000, 32'sh7fffffff, 1'b1);
		for (int phase = 0; phase < 5; phase++) begin
			drain_and_set(phase == 4 ? 22'($urandom_range(0, 22'h3fffff)) : widths[phase]);
			for (int k = 0; k < 290; ) begin
				n = $urandom_range(1, 8);
				kind = $urandom_range(0, 5);
				x = rand_coord(kind);
				y = rand_coord(kind);
				for (int j = 0; j < n; j++) begin
					if (kind >= 3) begin
						x = x + $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
						y = y + $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
					end else begin
						x = rand_coord(kind);
						y = rand_coord(kind);
					end
					send_point(x, y, j == n - 1);
					k++;
				end
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#30000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
